[rtl/mds_pkg.sv]
// Shared constants, types and the elaboration-time tan/coefficient table
// for the meridional diffusion stencil. No dependencies.
package mds_pkg;

    localparam int TEMP_W    = 16;
    localparam int PRES_W    = 24;
    localparam int DIFF_W    = 40;
    localparam int BAND_W    = 8;
    localparam int LATITUDES = 181;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 3;
    localparam int MUL_W     = 24;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 64;
    localparam int CQ_W      = 36;
    localparam int K1_W      = 37;
    localparam int MAG_W     = 40;
    localparam int TAN_N     = 90;
    localparam int DEG_W     = 7;

    localparam logic [BAND_W-1:0] LAST_BAND    = BAND_W'(LATITUDES - 1);
    localparam logic [BAND_W-1:0] EQUATOR_BAND = BAND_W'(90);
    localparam logic [BAND_W-1:0] MAX_DEG      = BAND_W'(TAN_N - 1);

    localparam logic [K1_W-1:0] K1_Q32  = 37'd74727593336;
    localparam logic [63:0]     K2_Q32  = 64'd652121273;
    localparam logic [63:0]     DEG_Q28 = 64'd4685083;
    localparam logic [63:0]     ONE_Q28 = 64'd268435456;

    localparam logic [PRES_W-1:0] PRES_RESET = 24'd65536;

    // Register indexes on the configuration port
    localparam logic REG_AIR_PRESSURE = 1'b0;

    typedef logic [TAN_N-1:0][CQ_W-1:0] t_cq_rom;

    // One pass through the shared multiply-accumulate unit
    typedef struct packed {
        logic             issue;
        logic             clear;
        logic             hi;
        logic             sub;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_op;

    // Restoring division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tan magnitude in Q.16 from an eleven-term series for sin and cos in Q.28
    function automatic logic [63:0] tan_q16(input int deg);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        st;
        logic [63:0]        ct;
        logic signed [63:0] s;
        logic signed [63:0] c;
        x  = 64'(deg) * DEG_Q28;
        x2 = (x * x) >> 28;
        st = x;
        ct = ONE_Q28;
        s  = signed'(x);
        c  = signed'(ONE_Q28);
        for (int k = 1; k <= 10; k++) begin
            st = udiv64((st * x2) >> 28, 64'((2 * k) * (2 * k + 1)));
            ct = udiv64((ct * x2) >> 28, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) != 0) begin
                s = s - signed'(st);
                c = c - signed'(ct);
            end else begin
                s = s + signed'(st);
                c = c + signed'(ct);
            end
        end
        if (s < 0) s = 0;
        if (c <= 0) c = 1;
        return udiv64(unsigned'(s) << 16, unsigned'(c));
    endfunction

    // First-difference coefficient per degree, Q.32
    function automatic t_cq_rom build_cq_rom();
        t_cq_rom     rom;
        logic [63:0] t;
        logic [63:0] p;
        for (int d = 0; d < TAN_N; d++) begin
            t      = tan_q16(d);
            p      = (K2_Q32 * t + 64'd32768) >> 16;
            rom[d] = p[CQ_W-1:0];
        end
        return rom;
    endfunction

    localparam t_cq_rom CQ_ROM = build_cq_rom();

endpackage

[rtl/mds_in_if.sv]
// Input stream channel: one band temperature per transaction.
// Depends on mds_pkg for the field width.
interface mds_in_if;
    logic                         valid;
    logic                         ready;
    logic [mds_pkg::TEMP_W-1:0]   temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

[rtl/mds_out_if.sv]
// Result stream channel: diffusion term, band index and sweep end flag.
// Depends on mds_pkg for the field widths.
interface mds_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mds_pkg::DIFF_W-1:0]   diffusion;
    logic [mds_pkg::BAND_W-1:0]          band_index;
    logic                                last_band;

    modport source (output valid, output diffusion, output band_index, output last_band,
                    input ready);
    modport sink   (input valid, input diffusion, input band_index, input last_band,
                    output ready);
endinterface

[rtl/mds_cfg_regs.sv]
// APB-style configuration register file: holds air_pressure.
// Depends on mds_pkg.
module mds_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mds_pkg::ADDR_W-1:0]   paddr,
    input  logic [mds_pkg::APB_W-1:0]    pwdata,
    output logic [mds_pkg::APB_W-1:0]    prdata,
    output logic                         pready,
    output logic [mds_pkg::PRES_W-1:0]   o_air_pressure
);
    import mds_pkg::*;

    logic [PRES_W-1:0] r_air_pressure;
    logic              wr_en;

    // word index is paddr[2]; byte lanes are ignored
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_AIR_PRESSURE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air_pressure <= PRES_RESET;
        end else if (wr_en) begin
            r_air_pressure <= pwdata[PRES_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_AIR_PRESSURE) begin
            prdata = APB_W'(r_air_pressure);
        end
    end

    assign pready         = 1'b1;
    assign o_air_pressure = r_air_pressure;
endmodule

[rtl/mds_mac_unit.sv]
// Shared 24x24 multiplier with a registered product and a 64-bit
// accumulator that adds or subtracts each product at offset 0 or 24.
// Depends on mds_pkg.
module mds_mac_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mds_pkg::t_mul_op          i_op,
    output logic [mds_pkg::ACC_W-1:0] o_acc
);
    import mds_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic              r_issue;
    logic              r_clear;
    logic              r_hi;
    logic              r_sub;
    logic [ACC_W-1:0]  r_acc;

    logic [ACC_W-1:0]  addend;
    logic [ACC_W-1:0]  base;

    always_comb begin
        addend = r_hi ? {r_prod[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}} : ACC_W'(r_prod);
        base   = r_clear ? '0 : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
        end else begin
            r_issue <= i_op.issue;
        end
        r_prod  <= PROD_W'(i_op.a) * PROD_W'(i_op.b);
        r_clear <= i_op.clear;
        r_hi    <= i_op.hi;
        r_sub   <= i_op.sub;
        if (r_issue) begin
            r_acc <= r_sub ? base - addend : base + addend;
        end
    end

    assign o_acc = r_acc;
endmodule

[rtl/meridional_diffusion_stencil.sv]
// Top level of the meridional diffusion stencil: band sequencer, window
// and output register. Depends on mds_pkg, mds_in_if, mds_out_if,
// mds_cfg_regs and mds_mac_unit.
//
//   channel   | kind            | payload
//   ----------+-----------------+---------------------------------------------
//   i_in      | stream sink     | temperature[15:0] Q10.6 K
//   o_out     | stream source   | diffusion[39:0] Q24.16, band_index[7:0], last_band
//   apb       | register port   | air_pressure[23:0] Q8.16 at byte address 0
//
// i_in.ready is high only while the sequencer idles. After the transaction of an
// interior band the block makes six passes through the one shared 24x24
// multiplier plus drain, round and finish before it takes the next band;
// band 0 emits a zero result, band 1 none, the last band an extra pole result.
// Reset (synchronous, active low) clears the counter, window, sequencer and
// output valid; air_pressure returns to 1.0. A stalled o_out holds the result
// register; the sequencer waits in its finish or pole state until the register frees.
module meridional_diffusion_stencil (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mds_in_if.sink                       i_in,
    mds_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mds_pkg::ADDR_W-1:0]   paddr,
    input  logic [mds_pkg::APB_W-1:0]    pwdata,
    output logic [mds_pkg::APB_W-1:0]    prdata,
    output logic                         pready
);
    import mds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INNER,
        ST_ROUND,
        ST_PRES,
        ST_FIN,
        ST_POLE
    } t_state;

    localparam logic [2:0] INNER_LAST_STEP = 3'd4;
    localparam logic [2:0] PRES_LAST_STEP  = 3'd2;
    localparam logic [MAG_W:0] MAG_POS_MAX = (41'd1 << (DIFF_W - 1)) - 41'd1;
    localparam logic [MAG_W:0] MAG_NEG_MAX = 41'd1 << (DIFF_W - 1);

    // sequencer and window
    t_state              r_state;
    logic [2:0]          r_step;
    logic [BAND_W-1:0]   r_cnt;
    logic [TEMP_W-1:0]   r_prev;
    logic [TEMP_W-1:0]   r_older;

    // operands of the band in flight
    logic [BAND_W-1:0]   r_band;
    logic [BAND_W-1:0]   r_pole_band;
    logic                r_pole_last;
    logic                r_pole_pend;
    logic                r_south;
    logic [TEMP_W-1:0]   r_d1_mag;
    logic                r_d1_neg;
    logic [TEMP_W:0]     r_s2_mag;
    logic                r_s2_neg;
    logic [CQ_W-1:0]     r_cq;
    logic                r_neg;
    logic [MAG_W-1:0]    r_mag;

    // output register
    logic                      r_out_vld;
    logic signed [DIFF_W-1:0]  r_out_diff;
    logic [BAND_W-1:0]         r_out_band;
    logic                      r_out_last;

    logic [PRES_W-1:0]   air_pressure;
    t_mul_op             mul_op;
    logic [ACC_W-1:0]    acc;

    logic                in_fire;
    logic                out_free;
    logic [BAND_W-1:0]   band_cur;
    logic [BAND_W-1:0]   band_ctr;
    logic                south;
    logic [BAND_W-1:0]   deg_full;
    logic [DEG_W-1:0]    deg;
    logic [TEMP_W:0]     d1;
    logic [TEMP_W+1:0]   s2;
    logic [TEMP_W:0]     d1_abs;
    logic [TEMP_W+1:0]   s2_abs;
    logic                acc_neg;
    logic [ACC_W-1:0]    acc_abs;
    logic [ACC_W-1:0]    acc_rnd;
    logic [MAG_W:0]      fin_mag;
    logic [MAG_W:0]      fin_clip;
    logic [DIFF_W-1:0]   fin_diff;

    mds_cfg_regs u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_air_pressure (air_pressure)
    );

    mds_mac_unit u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mul_op),
        .o_acc   (acc)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_vld || o_out.ready;

    // Decode the incoming band: a counter past the last band restarts a sweep
    always_comb begin
        band_cur = (r_cnt > LAST_BAND) ? '0 : r_cnt;
        band_ctr = band_cur - BAND_W'(1);
        south    = band_ctr < EQUATOR_BAND;
        deg_full = south ? EQUATOR_BAND - band_ctr : band_ctr - EQUATOR_BAND;
        deg      = (deg_full > MAX_DEG) ? MAX_DEG[DEG_W-1:0] : deg_full[DEG_W-1:0];
        d1       = {1'b0, i_in.temperature} - {1'b0, r_older};
        s2       = {2'b00, i_in.temperature} + {2'b00, r_older} - {1'b0, r_prev, 1'b0};
        d1_abs   = d1[TEMP_W] ? -d1 : d1;
        s2_abs   = s2[TEMP_W+1] ? -s2 : s2;
    end

    // Issue passes to the shared unit. Inner term:
    //   inner = K1*s2 - sign*cq*d1, taken as four 24-bit partial products.
    // Pressure term: |inner| rounded to Q.24 times air_pressure, two passes.
    always_comb begin
        mul_op = '0;
        case (r_state)
            ST_INNER: begin
                case (r_step)
                    3'd0: begin
                        mul_op.issue = 1'b1;
                        mul_op.clear = 1'b1;
                        mul_op.sub   = (r_south == r_d1_neg);
                        mul_op.a     = r_cq[MUL_W-1:0];
                        mul_op.b     = MUL_W'(r_d1_mag);
                    end
                    3'd1: begin
                        mul_op.issue = 1'b1;
                        mul_op.hi    = 1'b1;
                        mul_op.sub   = (r_south == r_d1_neg);
                        mul_op.a     = MUL_W'(r_cq[CQ_W-1:MUL_W]);
                        mul_op.b     = MUL_W'(r_d1_mag);
                    end
                    3'd2: begin
                        mul_op.issue = 1'b1;
                        mul_op.sub   = r_s2_neg;
                        mul_op.a     = K1_Q32[MUL_W-1:0];
                        mul_op.b     = MUL_W'(r_s2_mag);
                    end
                    3'd3: begin
                        mul_op.issue = 1'b1;
                        mul_op.hi    = 1'b1;
                        mul_op.sub   = r_s2_neg;
                        mul_op.a     = MUL_W'(K1_Q32[K1_W-1:MUL_W]);
                        mul_op.b     = MUL_W'(r_s2_mag);
                    end
                    default: begin
                        mul_op = '0;
                    end
                endcase
            end
            ST_PRES: begin
                case (r_step)
                    3'd0: begin
                        mul_op.issue = 1'b1;
                        mul_op.clear = 1'b1;
                        mul_op.a     = r_mag[MUL_W-1:0];
                        mul_op.b     = air_pressure;
                    end
                    3'd1: begin
                        mul_op.issue = 1'b1;
                        mul_op.hi    = 1'b1;
                        mul_op.a     = MUL_W'(r_mag[MAG_W-1:MUL_W]);
                        mul_op.b     = air_pressure;
                    end
                    default: begin
                        mul_op = '0;
                    end
                endcase
            end
            default: begin
                mul_op = '0;
            end
        endcase
    end

    // Round half away from zero: inner to Q.24, then the product to Q.16,
    // and clip to the signed 40-bit range.
    always_comb begin
        acc_neg  = acc[ACC_W-1];
        acc_abs  = acc_neg ? -acc : acc;
        acc_rnd  = acc_abs + ACC_W'(8192);
        fin_mag  = {1'b0, acc[ACC_W-1:MUL_W]} + (MAG_W+1)'(acc[MUL_W-1]);
        if (r_neg) begin
            fin_clip = (fin_mag > MAG_NEG_MAX) ? MAG_NEG_MAX : fin_mag;
            fin_diff = -fin_clip[DIFF_W-1:0];
        end else begin
            fin_clip = (fin_mag > MAG_POS_MAX) ? MAG_POS_MAX : fin_mag;
            fin_diff = fin_clip[DIFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_prev      <= '0;
            r_older     <= '0;
            r_pole_pend <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            // drop the result once the sink takes it; the finish and pole
            // states load the register themselves when it frees
            if (r_out_vld && o_out.ready && r_state != ST_FIN && r_state != ST_POLE) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_older  <= r_prev;
                        r_prev   <= i_in.temperature;
                        r_cnt    <= (band_cur == LAST_BAND) ? '0 : band_cur + BAND_W'(1);
                        r_band   <= band_ctr;
                        r_south  <= south;
                        r_cq     <= CQ_ROM[deg];
                        r_d1_mag <= d1_abs[TEMP_W-1:0];
                        r_d1_neg <= d1[TEMP_W];
                        r_s2_mag <= s2_abs[TEMP_W:0];
                        r_s2_neg <= s2[TEMP_W+1];
                        r_step   <= '0;
                        if (band_cur == '0) begin
                            // south pole: zero result right away
                            r_pole_band <= '0;
                            r_pole_last <= 1'b0;
                            r_state     <= ST_POLE;
                        end else if (band_cur == BAND_W'(1)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_pole_band <= band_cur;
                            r_pole_last <= 1'b1;
                            r_pole_pend <= (band_cur == LAST_BAND);
                            r_state     <= ST_INNER;
                        end
                    end
                end
                ST_INNER: begin
                    // last step only drains the final product into the sum
                    if (r_step == INNER_LAST_STEP) begin
                        r_step  <= '0;
                        r_state <= ST_ROUND;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_ROUND: begin
                    r_neg   <= acc_neg;
                    r_mag   <= acc_rnd[MAG_W+13:14];
                    r_step  <= '0;
                    r_state <= ST_PRES;
                end
                ST_PRES: begin
                    if (r_step == PRES_LAST_STEP) begin
                        r_step  <= '0;
                        r_state <= ST_FIN;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_FIN: begin
                    // hold until the output register frees
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_diff <= signed'(fin_diff);
                        r_out_band <= r_band;
                        r_out_last <= 1'b0;
                        r_state    <= r_pole_pend ? ST_POLE : ST_IDLE;
                    end
                end
                ST_POLE: begin
                    if (out_free) begin
                        r_out_vld   <= 1'b1;
                        r_out_diff  <= '0;
                        r_out_band  <= r_pole_band;
                        r_out_last  <= r_pole_last;
                        r_pole_pend <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.diffusion  = r_out_diff;
    assign o_out.band_index = r_out_band;
    assign o_out.last_band  = r_out_last;
endmodule

[sim/meridional_diffusion_stencil_tb.sv]
// Self-checking testbench for meridional_diffusion_stencil: random and directed
// band sweeps, APB pressure writes, a bit-exact diffusion predictor and a scoreboard.
// Depends on mds_pkg, mds_in_if, mds_out_if and the RTL of the block.
`timescale 1ns / 1ps

module meridional_diffusion_stencil_tb;

    import mds_pkg::*;

    // Fixed-point constants of the diffusion term
    localparam longint          COEF_SECOND = 64'sd74727593336;  // Q.32
    localparam bit [63:0]       COEF_FIRST  = 64'd652121273;     // Q.32
    localparam bit [63:0]       RAD_PER_DEG = 64'd4685083;       // Q.28
    localparam bit [63:0]       UNIT_Q28    = 64'd268435456;
    localparam bit [63:0]       DIFF_MAX    = 64'd549755813887;
    localparam int              IDLE_PCT    = 26;
    localparam int              RANDOM_ITEMS = 1625;
    localparam int              SETTLE_CYCLES = 24;
    localparam int              HOLDOFF_CYCLES = 300;

    typedef struct packed {
        logic [DIFF_W-1:0] diffusion;
        logic [BAND_W-1:0] band_index;
        logic              last_band;
    } t_band_result;

    typedef enum int {
        PROFILE_SMOOTH,
        PROFILE_FRONT,
        PROFILE_NOISE,
        PROFILE_CHECKER
    } t_sweep_profile;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    mds_in_if  in_ch ();
    mds_out_if out_ch ();

    meridional_diffusion_stencil dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Temperatures waiting to be offered, and results the predictor expects
    logic [TEMP_W-1:0] temperature_q[$];
    t_band_result      band_results_q[$];

    // Predictor copy of the block's state and its configuration
    logic [BAND_W-1:0] next_band;
    logic [TEMP_W-1:0] window_mid;
    logic [TEMP_W-1:0] window_old;
    logic [PRES_W-1:0] pressure_cfg;
    bit   [63:0]       slope_coef [TAN_N];

    bit in_fire;        // set at the edge that takes an input transaction
    bit no_idle;        // both sides run at full rate while set
    int holdoff_left;   // cycles the result side still holds ready low
    int errors;

    // Stimulus generator state, mirrors the band position of queued items
    int             gen_band;
    t_sweep_profile gen_profile;
    int             gen_base;
    int             gen_amp;
    int             gen_noise;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit, several times the slowest correct run
    initial begin
        #1_000_000;
        $display("meridional_diffusion_stencil test failed");
        $finish;
    end

    // tan magnitude in Q.16 from truncated eleven-term series for sin and cos in Q.28
    function automatic bit [63:0] tan_magnitude(input int deg);
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] st;
        bit [63:0] ct;
        longint    s;
        longint    c;
        x  = 64'(deg) * RAD_PER_DEG;
        x2 = (x * x) >> 28;
        st = x;
        ct = UNIT_Q28;
        s  = longint'(x);
        c  = longint'(UNIT_Q28);
        for (int k = 1; k <= 10; k++) begin
            st = ((st * x2) >> 28) / 64'((2 * k) * (2 * k + 1));
            ct = ((ct * x2) >> 28) / 64'((2 * k - 1) * (2 * k));
            if ((k & 1) != 0) begin
                s = s - longint'(st);
                c = c - longint'(ct);
            end else begin
                s = s + longint'(st);
                c = c + longint'(ct);
            end
        end
        if (s < 0) s = 0;
        if (c <= 0) c = 1;
        return (64'(s) << 16) / 64'(c);
    endfunction

    // Diffusion of one interior band in Q24.16, saturated to 40 bits
    function automatic logic [DIFF_W-1:0] interior_diffusion(input int band,
                                                            input logic [TEMP_W-1:0] t_south,
                                                            input logic [TEMP_W-1:0] t_mid,
                                                            input logic [TEMP_W-1:0] t_north,
                                                            input logic [PRES_W-1:0] pres);
        longint    d1;
        longint    s2;
        longint    term1;
        longint    inner;
        bit        south;
        bit        neg;
        int        deg;
        bit [63:0] mag;
        bit [63:0] prod;
        bit [63:0] res;
        d1    = longint'(t_north) - longint'(t_south);
        s2    = longint'(t_north) + longint'(t_south) - 2 * longint'(t_mid);
        south = band < 90;
        deg   = south ? 90 - band : band - 90;
        if (deg > 89) deg = 89;
        term1 = longint'(slope_coef[deg]) * d1;
        if (south) term1 = -term1;
        inner = COEF_SECOND * s2 - term1;
        neg   = inner < 0;
        mag   = neg ? 64'(-inner) : 64'(inner);
        // round half away from zero to Q.24, scale by pressure, round to Q.16
        mag   = (mag + 64'd8192) >> 14;
        prod  = mag * 64'(pres);
        mag   = (prod >> 24) + ((prod >> 23) & 64'd1);
        if (neg) begin
            if (mag > DIFF_MAX + 64'd1) mag = DIFF_MAX + 64'd1;
            res = 64'd0 - mag;
        end else begin
            if (mag > DIFF_MAX) mag = DIFF_MAX;
            res = mag;
        end
        return res[DIFF_W-1:0];
    endfunction

    // Advance the band window by one temperature and queue what it emits
    task automatic predict_band(input logic [TEMP_W-1:0] t);
        int           c;
        t_band_result r;
        c = int'(next_band);
        if (c >= LATITUDES) c = 0;
        if (c == 0) begin
            // south pole: zero result right away
            r = '{diffusion: '0, band_index: '0, last_band: 1'b0};
            band_results_q.push_back(r);
        end else if (c >= 2) begin
            r.diffusion  = interior_diffusion(c - 1, window_old, window_mid, t, pressure_cfg);
            r.band_index = BAND_W'(c - 1);
            r.last_band  = 1'b0;
            band_results_q.push_back(r);
        end
        if (c == LATITUDES - 1) begin
            // north pole: second, zero result closes the sweep
            r = '{diffusion: '0, band_index: BAND_W'(c), last_band: 1'b1};
            band_results_q.push_back(r);
            next_band = '0;
        end else begin
            next_band = BAND_W'(c + 1);
        end
        window_old = window_mid;
        window_mid = t;
    endtask

    // Take the input transaction and predict its results
    always @(posedge i_clk) begin : take_input
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_band(in_ch.temperature);
            in_fire = 1'b1;
        end
    end

    // Input driver: hold a temperature until taken, then maybe idle before the next
    always @(negedge i_clk) begin : drive_input
        logic              nxt_valid;
        logic [TEMP_W-1:0] nxt_temp;
        nxt_valid = in_ch.valid;
        nxt_temp  = in_ch.temperature;
        if (in_fire) begin
            in_fire   = 1'b0;
            nxt_valid = 1'b0;
        end
        if (!nxt_valid && i_rst_n && temperature_q.size() > 0 &&
            (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
            nxt_valid = 1'b1;
            nxt_temp  = temperature_q.pop_front();
        end
        in_ch.valid       <= nxt_valid;
        in_ch.temperature <= nxt_temp;
    end

    // Result side ready: random stalls, plus a long hold-off when requested
    always @(negedge i_clk) begin : drive_ready
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Scoreboard: compare every result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_band_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (band_results_q.size() == 0) begin
                errors++;
                $error("unpredicted result: band_index %0d diffusion %h",
                       out_ch.band_index, out_ch.diffusion);
            end else begin
                want = band_results_q.pop_front();
                if (out_ch.diffusion !== want.diffusion) begin
                    errors++;
                    $error("diffusion: expected %h, actual %h (band %0d)",
                           want.diffusion, out_ch.diffusion, want.band_index);
                end
                if (out_ch.band_index !== want.band_index) begin
                    errors++;
                    $error("band_index: expected %0d, actual %0d",
                           want.band_index, out_ch.band_index);
                end
                if (out_ch.last_band !== want.last_band) begin
                    errors++;
                    $error("last_band: expected %b, actual %b (band %0d)",
                           want.last_band, out_ch.last_band, want.band_index);
                end
            end
        end
    end

    // Wait until every queued item is taken and every result has arrived,
    // then give the block time to finish a band that emits nothing
    task automatic settle_block();
        while (temperature_q.size() != 0 || in_ch.valid || in_fire ||
               band_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of air_pressure: setup phase, then access phase until pready
    task automatic write_pressure(input logic [PRES_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(REG_AIR_PRESSURE));
        pwdata  <= APB_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pressure_cfg = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [TEMP_W-1:0] clamp_temp(input int v);
        if (v < 0) return '0;
        if (v > 65535) return '1;
        return TEMP_W'(v);
    endfunction

    // Queue temperatures sweep by sweep; each sweep draws a profile
    task automatic queue_sweeps(input int count);
        int r;
        int from_equator;
        int v;
        for (int i = 0; i < count; i++) begin
            if (gen_band == 0) begin
                r = $urandom_range(0, 99);
                if (r < 60)      gen_profile = PROFILE_SMOOTH;
                else if (r < 75) gen_profile = PROFILE_FRONT;
                else if (r < 88) gen_profile = PROFILE_NOISE;
                else             gen_profile = PROFILE_CHECKER;
                gen_base  = $urandom_range(8000, 22000);
                gen_amp   = $urandom_range(0, 6000);
                gen_noise = $urandom_range(0, 400);
            end
            from_equator = (gen_band < 90) ? 90 - gen_band : gen_band - 90;
            case (gen_profile)
                PROFILE_SMOOTH: begin
                    // warm equator, cold poles, a little noise
                    v = gen_base + (gen_amp * (90 - from_equator)) / 90 +
                        int'($urandom_range(0, gen_noise)) - gen_noise / 2;
                end
                PROFILE_FRONT: begin
                    // sharp step at a random band stresses the first difference
                    v = gen_base + ((gen_band > 60 + gen_amp % 60) ? gen_amp * 4 : 0) +
                        int'($urandom_range(0, gen_noise));
                end
                PROFILE_NOISE: v = int'($urandom_range(0, 65535));
                default:       v = ((gen_band & 1) != 0) ? 65535 : 0;
            endcase
            temperature_q.push_back(clamp_temp(v));
            gen_band = (gen_band == LATITUDES - 1) ? 0 : gen_band + 1;
        end
    endtask

    initial begin : stimulus
        logic [PRES_W-1:0] pres;
        int                sent;
        int                chunk;
        int                phase;

        // Drive every block input to a known value from time zero
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.temperature = '0;
        out_ch.ready      = 1'b0;
        in_fire           = 1'b0;
        no_idle           = 1'b0;
        holdoff_left      = 0;
        errors            = 0;
        next_band         = '0;
        window_mid        = '0;
        window_old        = '0;
        pressure_cfg      = PRES_RESET;
        for (int d = 0; d < TAN_N; d++)
            slope_coef[d] = (COEF_FIRST * tan_magnitude(d) + 64'd32768) >> 16;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes at reset pressure, starting at the south pole
        temperature_q = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                          16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF};
        settle_block();

        // Directed: full pressure with a checkerboard drives both saturation limits
        write_pressure('1);
        for (int i = 0; i < 13; i++)
            temperature_q.push_back(((i & 1) != 0) ? 16'h0000 : 16'hFFFF);
        settle_block();
        gen_band = 25;

        // Random sweeps in phases, one pressure setting per phase
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0:       pres = '0;
                1:       pres = '1;
                2:       pres = PRES_RESET;
                3:       pres = 24'd1;
                default: pres = ($urandom_range(0, 3) == 0) ? PRES_W'($urandom())
                                                            : PRES_W'($urandom_range(52000, 80000));
            endcase
            write_pressure(pres);
            @(posedge i_clk);
            no_idle = (phase == 2);
            // stall results long enough that the block fills and blocks its input
            if (phase == 4) holdoff_left = HOLDOFF_CYCLES;
            chunk = $urandom_range(120, 260);
            if (chunk > RANDOM_ITEMS - sent) chunk = RANDOM_ITEMS - sent;
            queue_sweeps(chunk);
            sent += chunk;
            settle_block();
            phase++;
        end
        no_idle = 1'b0;

        if (errors == 0 && band_results_q.size() == 0) begin
            $display("meridional_diffusion_stencil test passed");
        end else begin
            $display("meridional_diffusion_stencil test failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/mds_pkg.sv
rtl/mds_in_if.sv
rtl/mds_out_if.sv
rtl/mds_cfg_regs.sv
rtl/mds_mac_unit.sv
rtl/meridional_diffusion_stencil.sv
sim/meridional_diffusion_stencil_tb.sv
